// File: rtl/assert_macros.svh
// Assertion macros shared by the reversible deque RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RDQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RDQ_ASSERT(lbl, prop, msg)
`define RDQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/rdq_pkg.sv
// Package for the reversible deque: sizes, operation codes, ring helpers
// and the command and status structs between controller and datapath.
package rdq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_HEAD = 3'd0,
    KIND_PUSH_TAIL = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_REVERSE   = 3'd3,
    KIND_CLEAR     = 3'd4
  } kind_t;

  typedef struct packed {
    logic exec;  // perform the accepted operation on the store
    logic load;  // move the finished result into the output register
  } dq_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds a result that is not taken
  } dq_sts_t;

  // (a + b) modulo CAPACITY, valid for a < CAPACITY and b <= CAPACITY.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return IDX_W'(s);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/rdq_channels.sv
// Valid/ready channel interfaces for the reversible deque.
// Depends on rdq_pkg for the field widths.
interface rdq_in_if;
  import rdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] item_value;
  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

interface rdq_out_if;
  import rdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] removed_value;
  logic [CNT_W-1:0]         count;
  modport source (output valid, output ok, output removed_value, output count,
                  input ready);
  modport sink   (input valid, input ok, input removed_value, input count,
                  output ready);
endinterface

// File: rtl/rdq_ctrl.sv
// Controller of the reversible deque: accepts one operation, then loads
// its result into the output register. Depends on rdq_pkg.
`include "assert_macros.svh"
module rdq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rdq_pkg::dq_sts_t sts,
  output rdq_pkg::dq_cmd_t cmd
);
  import rdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.exec = in_valid && in_ready;
  assign cmd.load = (state_r == ST_LOAD) && !sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.exec) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd.load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RDQ_ASSERT(a_load_when_free, cmd.load |-> !sts.out_busy, "result loaded over a waiting one")
  `RDQ_ASSERT(a_exec_then_load, cmd.exec |=> (state_r == ST_LOAD && !in_ready), "no load after exec")

endmodule

// File: rtl/rdq_datapath.sv
// Datapath of the reversible deque: ring store, pointers, direction flag
// and the output register. Depends on rdq_pkg.
`include "assert_macros.svh"
module rdq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rdq_pkg::dq_cmd_t                  cmd,
  output rdq_pkg::dq_sts_t                  sts,
  input  logic [rdq_pkg::KIND_W-1:0]        kind,
  input  logic signed [rdq_pkg::DATA_W-1:0] item_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic signed [rdq_pkg::DATA_W-1:0] removed_value,
  output logic [rdq_pkg::CNT_W-1:0]         count
);
  import rdq_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic              ok_r, ok_nxt;
  logic              pop_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [DATA_W-1:0] out_val_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              full, empty, at_low;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    ok_nxt    = 1'b0;
    at_low    = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = front_r;
    rd_addr   = front_r;
    unique case (kind)
      KIND_PUSH_HEAD, KIND_PUSH_TAIL: begin
        if (!full) begin
          // With the direction flag set, head and tail swap physical ends.
          at_low = (kind == KIND_PUSH_HEAD) != rev_r;
          ok_nxt = 1'b1;
          wr_en  = 1'b1;
          if (at_low) begin
            wr_addr   = ring_dec(front_r);
            front_nxt = wr_addr;
          end else begin
            wr_addr = ring_add(front_r, count_r);
          end
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP_HEAD: begin
        if (!empty) begin
          ok_nxt = 1'b1;
          rd_en  = 1'b1;
          if (!rev_r) begin
            rd_addr   = front_r;
            front_nxt = ring_add(front_r, CNT_W'(1));
          end else begin
            rd_addr = ring_add(front_r, count_r - 1'b1);
          end
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_REVERSE: begin
        rev_nxt = !rev_r;
        ok_nxt  = 1'b1;
      end
      KIND_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
        rev_nxt   = 1'b0;
        ok_nxt    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Ring store: one write or one registered read per operation.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= item_value;
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      ok_r    <= 1'b0;
      pop_r   <= 1'b0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      ok_r    <= ok_nxt;
      pop_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok_r  <= ok_r;
      out_val_r <= pop_r ? rd_data_r : '0;
      out_cnt_r <= count_r;
    end
  end

  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign ok            = out_ok_r;
  assign removed_value = out_val_r;
  assign count         = out_cnt_r;

  `RDQ_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `RDQ_ASSERT(a_pop_dec, (cmd.exec && kind == KIND_POP_HEAD && !empty) |=> (count_r == $past(count_r) - 1'b1), "remove did not drop count")
  `RDQ_ASSERT_RST(a_reset_empty, $past(!rst_n) |-> (count_r == '0 && !rev_r && !out_valid_r), "state not clear after reset")

endmodule

// File: rtl/reversible_deque.sv
// Reversible deque: a bounded double-ended queue of 16 signed 32-bit values
// in a ring store, with insert at head or tail, remove from head, reverse
// and clear. Each operation yields one result (ok, removed value, count).
// An operation is accepted while the controller is idle; the controller
// then loads its result into the output register once that register is
// free, so a new operation is taken only after the last result is loaded.
// A result left waiting in the output register still lets one more
// operation be accepted, but that operation's result cannot be loaded, so
// the input stays closed until the waiting result is transferred.
module reversible_deque (
  input  logic      clk,
  input  logic      rst_n,
  rdq_in_if.sink    in_ch,
  rdq_out_if.source out_ch
);
  import rdq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  rdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (in_ch.kind),
    .item_value    (in_ch.item_value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .ok            (out_ch.ok),
    .removed_value (out_ch.removed_value),
    .count         (out_ch.count)
  );

endmodule
